@@ rtl/banked_memory_map_decoder_top_macros.svh @@
// ----------------------------------------------------------------------------
// banked memory map decoder assertion macros
// shared concurrent assertion forms for the decoder rtl
// ----------------------------------------------------------------------------
`ifndef BANKED_MEMORY_MAP_DECODER_TOP_MACROS_SVH
`define BANKED_MEMORY_MAP_DECODER_TOP_MACROS_SVH

// consequent checked at the same edge
`define BMMD_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// consequent checked at the following edge
`define BMMD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/bmmd_pkg.sv @@
// ----------------------------------------------------------------------------
// bmmd_pkg
// types, codes and constants of the banked memory map decoder
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bmmd_pkg;

   localparam int CART_ADDR_BITS_DEF = 20;
   localparam int ADDR_W             = 16;
   localparam int DATA_W             = 8;
   localparam int PAGE_W             = 8;
   localparam int PTYPE_W            = 3;
   localparam int CMD_W              = 2;
   localparam int BANK_W             = 8;
   localparam int MASK_W             = 20;
   localparam int CSR_IDX_W          = 2;
   localparam int CSR_DATA_W         = 20;
   localparam int SUM_W              = 25;
   localparam int NUM_PAGES          = 256;
   localparam int MAIN_DEPTH         = 65536;
   localparam int QUEUE_DEPTH        = 2;
   localparam int BANK_LOW_SHIFT     = 12;
   localparam int BANK_HIGH_SHIFT    = 16;

   localparam logic [ADDR_W-1:0] MRAM_MASK    = 16'h01FF;
   localparam logic [ADDR_W-1:0] MRAM_BASE    = 16'h0800;
   localparam logic [ADDR_W-1:0] MROM_MASK    = 16'h03FF;
   localparam logic [ADDR_W-1:0] MMULTI_MASK  = 16'h0FFF;
   localparam logic [ADDR_W-1:0] SYSROM_LIMIT = 16'h0400;
   localparam logic [DATA_W-1:0] UNDEF_DATA   = 8'hFF;
   localparam logic [MASK_W-1:0] MASK_RESET   = 20'hFFFFF;

   typedef enum logic [CMD_W-1:0] {
      CMD_READ     = 2'd0,
      CMD_WRITE    = 2'd1,
      CMD_SET_PAGE = 2'd2,
      CMD_NONE     = 2'd3
   } cmd_type;

   typedef enum logic [PTYPE_W-1:0] {
      PT_UNDEF  = 3'd0,
      PT_RAM    = 3'd1,
      PT_ROM    = 3'd2,
      PT_CART   = 3'd3,
      PT_MROM   = 3'd4,
      PT_MRAM   = 3'd5,
      PT_MULTI  = 3'd6,
      PT_MMULTI = 3'd7
   } page_kind_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BANK_LOW   = 2'd0,
      CSR_BANK_HIGH  = 2'd1,
      CSR_CART_MASK  = 2'd2,
      CSR_SYSROM_OFF = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      OP_NONE  = 2'd0,
      OP_READ  = 2'd1,
      OP_WRITE = 2'd2
   } op_kind_type;

   typedef enum logic [1:0] {
      RES_ZERO = 2'd0,
      RES_FF   = 2'd1,
      RES_MAIN = 2'd2,
      RES_CART = 2'd3
   } res_sel_type;

   typedef struct packed {
      op_kind_type       op;
      logic              to_cart;
      logic              undef;
      logic [ADDR_W-1:0] main_addr;
      logic [DATA_W-1:0] wdata;
   } mem_op_type;

endpackage

@@ rtl/banked_memory_map_decoder_top.sv @@
// a result passes the front stage registers, a queue entry and a registered memory read
// to rsp_read_data; throughput: one command per cycle unless stalled, set by the single
// back end memory access per cycle; the two-entry queue lets front and back stall apart
// reset clears control state, config registers and the page valid bits (all pages
// undefined); main and cartridge memories are not cleared, there is no clearing pass
// ----------------------------------------------------------------------------
// banked_memory_map_decoder_top
// paged memory map with mirrors and a banked multicart rom
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "banked_memory_map_decoder_top_macros.svh"

module banked_memory_map_decoder_top #(
   parameter int CART_ADDR_BITS = bmmd_pkg::CART_ADDR_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              push,
   output logic                              full,
   input  logic [bmmd_pkg::CMD_W-1:0]        req_cmd,
   input  logic [bmmd_pkg::ADDR_W-1:0]       req_address,
   input  logic [bmmd_pkg::DATA_W-1:0]       req_write_data,
   input  logic                              req_rom_write,
   input  logic [bmmd_pkg::PTYPE_W-1:0]      req_page_type,
   output logic                              empty,
   input  logic                              pop,
   output logic [bmmd_pkg::DATA_W-1:0]       rsp_read_data,
   input  logic                              csr_write_en,
   input  logic [bmmd_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [bmmd_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   localparam int OP_W = $bits(bmmd_pkg::mem_op_type);
   localparam int QW   = OP_W + CART_ADDR_BITS;

   logic                          front_valid;
   bmmd_pkg::mem_op_type          front_op;
   logic [CART_ADDR_BITS-1:0]     front_cart_addr;
   logic                          fifo_push;
   logic                          fifo_pop;
   logic                          fifo_full;
   logic                          fifo_empty;
   logic [QW-1:0]                 fifo_wr_data;
   logic [QW-1:0]                 fifo_rd_data;
   bmmd_pkg::mem_op_type          back_op;
   logic [CART_ADDR_BITS-1:0]     back_cart_addr;

   bmmd_front #(
      .CART_ADDR_BITS (CART_ADDR_BITS)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .push           (push),
      .full           (full),
      .req_cmd        (req_cmd),
      .req_address    (req_address),
      .req_write_data (req_write_data),
      .req_rom_write  (req_rom_write),
      .req_page_type  (req_page_type),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .op_valid       (front_valid),
      .op             (front_op),
      .op_cart_addr   (front_cart_addr),
      .fifo_full      (fifo_full)
   );

   assign fifo_push    = front_valid & ~fifo_full;
   assign fifo_wr_data = {front_op, front_cart_addr};

   bmmd_fifo #(
      .WIDTH (QW),
      .DEPTH (bmmd_pkg::QUEUE_DEPTH)
   ) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .wr_en      (fifo_push),
      .wr_data    (fifo_wr_data),
      .rd_en      (fifo_pop),
      .rd_data    (fifo_rd_data),
      .fifo_full  (fifo_full),
      .fifo_empty (fifo_empty)
   );

   assign back_op        = fifo_rd_data[QW-1:CART_ADDR_BITS];
   assign back_cart_addr = fifo_rd_data[CART_ADDR_BITS-1:0];

   bmmd_back #(
      .CART_ADDR_BITS (CART_ADDR_BITS)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .fifo_empty    (fifo_empty),
      .op            (back_op),
      .op_cart_addr  (back_cart_addr),
      .fifo_pop      (fifo_pop),
      .empty         (empty),
      .pop           (pop),
      .rsp_read_data (rsp_read_data)
   );

   `BMMD_ASSERT_SAME(a_fifo_no_overflow, clock, reset, fifo_push, !fifo_full, "queue written while full")
   `BMMD_ASSERT_SAME(a_fifo_no_underflow, clock, reset, fifo_pop, !fifo_empty, "queue read while empty")
   `BMMD_ASSERT_NEXT(a_front_hold, clock, reset, front_valid && fifo_full, front_valid, "stalled item lost")
   `BMMD_ASSERT_NEXT(a_issue_result, clock, reset, fifo_pop, !empty, "issued item gave no result")

endmodule

@@ rtl/bmmd_ram.sv @@
// ----------------------------------------------------------------------------
// bmmd_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bmmd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/bmmd_fifo.sv @@
// ----------------------------------------------------------------------------
// bmmd_fifo
// short flop queue between the decode front and the memory back
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bmmd_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = bmmd_pkg::QUEUE_DEPTH,
   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   localparam int CW = $clog2(DEPTH + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_en,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   output logic [WIDTH-1:0] rd_data,
   output logic             fifo_full,
   output logic             fifo_empty
);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (wr_en) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (rd_en) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (wr_en && !rd_en) begin
         count_in = count_ff + 1'b1;
      end else if (rd_en && !wr_en) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_ff[wr_ptr_ff] <= wr_data;
      end
   end

   assign rd_data    = entry_ff[rd_ptr_ff];
   assign fifo_full  = (count_ff == CW'(DEPTH));
   assign fifo_empty = (count_ff == '0);

endmodule

@@ rtl/bmmd_front.sv @@
// ----------------------------------------------------------------------------
// bmmd_front
// accepts commands, looks up the page type and maps the address
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bmmd_front #(
   parameter int CART_ADDR_BITS = bmmd_pkg::CART_ADDR_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                push,
   output logic                                full,
   input  logic [bmmd_pkg::CMD_W-1:0]          req_cmd,
   input  logic [bmmd_pkg::ADDR_W-1:0]         req_address,
   input  logic [bmmd_pkg::DATA_W-1:0]         req_write_data,
   input  logic                                req_rom_write,
   input  logic [bmmd_pkg::PTYPE_W-1:0]        req_page_type,
   input  logic                                csr_write_en,
   input  logic [bmmd_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [bmmd_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output logic                                op_valid,
   output bmmd_pkg::mem_op_type                op,
   output logic [CART_ADDR_BITS-1:0]           op_cart_addr,
   input  logic                                fifo_full
);

   localparam int AW = bmmd_pkg::ADDR_W;
   localparam int SW = bmmd_pkg::SUM_W;

   logic                              accept;
   logic                              pt_write;
   logic [bmmd_pkg::PAGE_W-1:0]       page;
   logic [bmmd_pkg::PTYPE_W-1:0]      pt_rd_data;
   logic [bmmd_pkg::NUM_PAGES-1:0]    pt_valid_ff, pt_valid_in;
   logic                              pt_hit_ff;
   logic                              s1_valid_ff, s1_valid_in;
   bmmd_pkg::cmd_type                 cmd_ff;
   logic [AW-1:0]                     addr_ff;
   logic [bmmd_pkg::DATA_W-1:0]       wdata_ff;
   logic                              romw_ff;
   logic [bmmd_pkg::BANK_W-1:0]       bank_low_ff;
   logic [bmmd_pkg::BANK_W-1:0]       bank_high_ff;
   logic [bmmd_pkg::MASK_W-1:0]       cart_mask_ff;
   logic                              sysrom_off_ff;
   bmmd_pkg::page_kind_type           kind;
   logic [AW-1:0]                     multi_addr;
   logic                              multi_main;
   logic [SW-1:0]                     cart_sum;
   logic [SW-1:0]                     cart_masked;
   bmmd_pkg::mem_op_type              dec;

   assign full     = s1_valid_ff & fifo_full;
   assign accept   = push & ~full;
   assign page     = req_address[AW-1:AW-bmmd_pkg::PAGE_W];
   assign pt_write = accept && (bmmd_pkg::cmd_type'(req_cmd) == bmmd_pkg::CMD_SET_PAGE);

   // page type table, valid bit per page gives the undefined reset
   bmmd_ram #(
      .WIDTH (bmmd_pkg::PTYPE_W),
      .DEPTH (bmmd_pkg::NUM_PAGES)
   ) u_page_ram (
      .clock   (clock),
      .wr_en   (pt_write),
      .wr_addr (page),
      .wr_data (req_page_type),
      .rd_en   (accept),
      .rd_addr (page),
      .rd_data (pt_rd_data)
   );

   always_comb begin
      pt_valid_in = pt_valid_ff;
      if (pt_write) begin
         pt_valid_in[page] = 1'b1;
      end
   end

   assign s1_valid_in = accept | (s1_valid_ff & fifo_full);

   always_ff @(posedge clock) begin
      if (reset) begin
         pt_valid_ff   <= '0;
         s1_valid_ff   <= 1'b0;
         bank_low_ff   <= '0;
         bank_high_ff  <= '0;
         cart_mask_ff  <= bmmd_pkg::MASK_RESET;
         sysrom_off_ff <= 1'b0;
      end else begin
         pt_valid_ff <= pt_valid_in;
         s1_valid_ff <= s1_valid_in;
         if (csr_write_en) begin
            unique case (bmmd_pkg::csr_index_type'(csr_index))
               bmmd_pkg::CSR_BANK_LOW:   bank_low_ff   <= csr_wdata[bmmd_pkg::BANK_W-1:0];
               bmmd_pkg::CSR_BANK_HIGH:  bank_high_ff  <= csr_wdata[bmmd_pkg::BANK_W-1:0];
               bmmd_pkg::CSR_CART_MASK:  cart_mask_ff  <= csr_wdata[bmmd_pkg::MASK_W-1:0];
               bmmd_pkg::CSR_SYSROM_OFF: sysrom_off_ff <= csr_wdata[0];
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff    <= bmmd_pkg::cmd_type'(req_cmd);
         addr_ff   <= req_address;
         wdata_ff  <= req_write_data;
         romw_ff   <= req_rom_write;
         pt_hit_ff <= pt_valid_ff[page];
      end
   end

   assign kind = pt_hit_ff ? bmmd_pkg::page_kind_type'(pt_rd_data) : bmmd_pkg::PT_UNDEF;

   // multicart target
   assign multi_addr = (kind == bmmd_pkg::PT_MMULTI) ? (addr_ff & bmmd_pkg::MMULTI_MASK)
                                                     : addr_ff;
   assign multi_main = (multi_addr < bmmd_pkg::SYSROM_LIMIT) && !sysrom_off_ff;
   assign cart_sum   = SW'(multi_addr)
                     + (SW'(bank_low_ff) << bmmd_pkg::BANK_LOW_SHIFT)
                     + (SW'(bank_high_ff) << bmmd_pkg::BANK_HIGH_SHIFT);
   assign cart_masked = cart_sum & SW'(cart_mask_ff);

   always_comb begin
      dec.op        = bmmd_pkg::OP_NONE;
      dec.to_cart   = 1'b0;
      dec.undef     = 1'b0;
      dec.main_addr = addr_ff;
      dec.wdata     = wdata_ff;
      unique case (cmd_ff)
         bmmd_pkg::CMD_READ: begin
            dec.op = bmmd_pkg::OP_READ;
            unique case (kind)
               bmmd_pkg::PT_UNDEF: dec.undef = 1'b1;
               bmmd_pkg::PT_MULTI, bmmd_pkg::PT_MMULTI: begin
                  dec.to_cart   = !multi_main;
                  dec.main_addr = multi_addr;
               end
               bmmd_pkg::PT_MRAM:
                  dec.main_addr = (addr_ff & bmmd_pkg::MRAM_MASK) | bmmd_pkg::MRAM_BASE;
               bmmd_pkg::PT_MROM: dec.main_addr = addr_ff & bmmd_pkg::MROM_MASK;
               bmmd_pkg::PT_RAM, bmmd_pkg::PT_ROM, bmmd_pkg::PT_CART: ;
            endcase
         end
         bmmd_pkg::CMD_WRITE: begin
            unique case (kind)
               bmmd_pkg::PT_RAM: dec.op = bmmd_pkg::OP_WRITE;
               bmmd_pkg::PT_MRAM: begin
                  dec.op        = bmmd_pkg::OP_WRITE;
                  dec.main_addr = (addr_ff & bmmd_pkg::MRAM_MASK) | bmmd_pkg::MRAM_BASE;
               end
               bmmd_pkg::PT_MULTI, bmmd_pkg::PT_MMULTI: begin
                  if (romw_ff) begin
                     dec.op = bmmd_pkg::OP_WRITE;
                  end
                  dec.to_cart   = !multi_main;
                  dec.main_addr = multi_addr;
               end
               bmmd_pkg::PT_UNDEF, bmmd_pkg::PT_ROM, bmmd_pkg::PT_CART,
               bmmd_pkg::PT_MROM: begin
                  if (romw_ff) begin
                     dec.op = bmmd_pkg::OP_WRITE;
                  end
               end
            endcase
         end
         bmmd_pkg::CMD_SET_PAGE, bmmd_pkg::CMD_NONE: ;
      endcase
   end

   assign op_valid     = s1_valid_ff;
   assign op           = dec;
   assign op_cart_addr = cart_masked[CART_ADDR_BITS-1:0];

endmodule

@@ rtl/bmmd_back.sv @@
// ----------------------------------------------------------------------------
// bmmd_back
// performs main and cartridge memory accesses and holds the result
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bmmd_back #(
   parameter int CART_ADDR_BITS = bmmd_pkg::CART_ADDR_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          fifo_empty,
   input  bmmd_pkg::mem_op_type          op,
   input  logic [CART_ADDR_BITS-1:0]     op_cart_addr,
   output logic                          fifo_pop,
   output logic                          empty,
   input  logic                          pop,
   output logic [bmmd_pkg::DATA_W-1:0]   rsp_read_data
);

   logic                          issue;
   logic                          is_read;
   logic                          is_write;
   logic                          main_wr, main_rd, cart_wr, cart_rd;
   logic [bmmd_pkg::DATA_W-1:0]   main_rd_data;
   logic [bmmd_pkg::DATA_W-1:0]   cart_rd_data;
   logic                          res_valid_ff, res_valid_in;
   bmmd_pkg::res_sel_type         res_sel_ff, res_sel_in;

   assign issue    = !fifo_empty && (!res_valid_ff || pop);
   assign is_read  = (op.op == bmmd_pkg::OP_READ);
   assign is_write = (op.op == bmmd_pkg::OP_WRITE);
   assign main_wr  = issue && is_write && !op.to_cart;
   assign cart_wr  = issue && is_write && op.to_cart;
   assign main_rd  = issue && is_read && !op.undef && !op.to_cart;
   assign cart_rd  = issue && is_read && !op.undef && op.to_cart;

   bmmd_ram #(
      .WIDTH (bmmd_pkg::DATA_W),
      .DEPTH (bmmd_pkg::MAIN_DEPTH)
   ) u_main_ram (
      .clock   (clock),
      .wr_en   (main_wr),
      .wr_addr (op.main_addr),
      .wr_data (op.wdata),
      .rd_en   (main_rd),
      .rd_addr (op.main_addr),
      .rd_data (main_rd_data)
   );

   bmmd_ram #(
      .WIDTH (bmmd_pkg::DATA_W),
      .DEPTH (2 ** CART_ADDR_BITS)
   ) u_cart_ram (
      .clock   (clock),
      .wr_en   (cart_wr),
      .wr_addr (op_cart_addr),
      .wr_data (op.wdata),
      .rd_en   (cart_rd),
      .rd_addr (op_cart_addr),
      .rd_data (cart_rd_data)
   );

   always_comb begin
      res_sel_in = bmmd_pkg::RES_ZERO;
      if (is_read) begin
         if (op.undef) begin
            res_sel_in = bmmd_pkg::RES_FF;
         end else if (op.to_cart) begin
            res_sel_in = bmmd_pkg::RES_CART;
         end else begin
            res_sel_in = bmmd_pkg::RES_MAIN;
         end
      end
   end

   assign res_valid_in = issue | (res_valid_ff & ~pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         res_valid_ff <= 1'b0;
      end else begin
         res_valid_ff <= res_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         res_sel_ff <= res_sel_in;
      end
   end

   always_comb begin
      unique case (res_sel_ff)
         bmmd_pkg::RES_ZERO: rsp_read_data = '0;
         bmmd_pkg::RES_FF:   rsp_read_data = bmmd_pkg::UNDEF_DATA;
         bmmd_pkg::RES_MAIN: rsp_read_data = main_rd_data;
         bmmd_pkg::RES_CART: rsp_read_data = cart_rd_data;
      endcase
   end

   assign fifo_pop = issue;
   assign empty    = ~res_valid_ff;

endmodule

@@ tb/banked_memory_map_decoder_top_tb.sv @@
// ----------------------------------------------------------------------------
// banked_memory_map_decoder_top_tb
// self-checking bench for the paged memory map decoder: a directed pass over
// every page kind, mirror fold and write rule, then random traffic under
// several bank and mask settings, checked against a behavioral model of the
// page table, main memory and multicart rom
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module banked_memory_map_decoder_top_tb;
   import bmmd_pkg::*;

   localparam int PHASES      = 8;
   localparam int PHASE_ITEMS = 75;
   localparam int POOL_DEPTH  = 48;
   localparam int CART_LIMIT  = (1 << CART_ADDR_BITS_DEF) - 1;

   typedef enum int {
      TGT_FIXED,
      TGT_MAIN,
      TGT_CART,
      TGT_NONE
   } target_kind_type;

   typedef struct {
      cmd_type           cmd;
      logic [ADDR_W-1:0] address;
      logic [DATA_W-1:0] wdata;
      logic              rom_write;
      page_kind_type     ptype;
   } mem_req_type;

   class memmap_scoreboard;
      page_kind_type     page_kind [NUM_PAGES];
      logic [DATA_W-1:0] main_mem [MAIN_DEPTH];
      bit                main_valid [MAIN_DEPTH];
      logic [DATA_W-1:0] cart_mem [int];
      logic [BANK_W-1:0] bank_lo;
      logic [BANK_W-1:0] bank_hi;
      logic [MASK_W-1:0] cart_mask;
      logic              sysrom_off;
      logic [DATA_W-1:0] read_data_due [$];
      int                errors;

      function new();
         foreach (page_kind[i]) page_kind[i] = PT_UNDEF;
         foreach (main_valid[i]) main_valid[i] = 1'b0;
         cart_mem.delete();
         bank_lo    = '0;
         bank_hi    = '0;
         cart_mask  = MASK_RESET;
         sysrom_off = 1'b0;
         errors     = 0;
      endfunction

      function void set_csr(csr_index_type idx, logic [CSR_DATA_W-1:0] val);
         case (idx)
            CSR_BANK_LOW:   bank_lo = val[BANK_W-1:0];
            CSR_BANK_HIGH:  bank_hi = val[BANK_W-1:0];
            CSR_CART_MASK:  cart_mask = val[MASK_W-1:0];
            CSR_SYSROM_OFF: sysrom_off = val[0];
            default: ;
         endcase
      endfunction

      function void resolve_target(input logic [ADDR_W-1:0] a, input bit is_write,
                                   input logic romw, output target_kind_type tk,
                                   output int idx);
         page_kind_type     kind;
         logic [ADDR_W-1:0] fa;
         int                off;
         kind = page_kind[a[15:8]];
         idx  = int'(a);
         tk   = TGT_MAIN;
         case (kind)
            PT_UNDEF: begin
               if (!is_write) tk = TGT_FIXED;
               else if (!romw) tk = TGT_NONE;
            end
            PT_RAM: ;
            PT_MRAM: idx = int'((a & MRAM_MASK) | MRAM_BASE);
            PT_MROM: begin
               if (!is_write) idx = int'(a & MROM_MASK);
               else if (!romw) tk = TGT_NONE;
            end
            PT_MULTI, PT_MMULTI: begin
               fa = (kind == PT_MMULTI) ? (a & MMULTI_MASK) : a;
               if (is_write && !romw) begin
                  tk = TGT_NONE;
               end else if (fa < SYSROM_LIMIT && !sysrom_off) begin
                  idx = int'(fa);
               end else begin
                  tk  = TGT_CART;
                  off = int'(fa) + (int'(bank_lo) << BANK_LOW_SHIFT)
                        + (int'(bank_hi) << BANK_HIGH_SHIFT);
                  idx = off & int'(cart_mask) & CART_LIMIT;
               end
            end
            default: begin
               if (is_write && !romw) tk = TGT_NONE;
            end
         endcase
      endfunction

      // reads of bytes never stored are turned into loading writes
      function mem_req_type legalize(mem_req_type it);
         target_kind_type tk;
         int              idx;
         if (it.cmd == CMD_READ) begin
            resolve_target(it.address, 1'b0, 1'b0, tk, idx);
            if ((tk == TGT_MAIN && !main_valid[idx]) ||
                (tk == TGT_CART && !cart_mem.exists(idx))) begin
               it.cmd       = CMD_WRITE;
               it.rom_write = 1'b1;
            end
         end
         return it;
      endfunction

      function void note_request(mem_req_type it);
         target_kind_type   tk;
         int                idx;
         logic [DATA_W-1:0] rd;
         rd = '0;
         case (it.cmd)
            CMD_READ: begin
               resolve_target(it.address, 1'b0, it.rom_write, tk, idx);
               case (tk)
                  TGT_FIXED: rd = UNDEF_DATA;
                  TGT_MAIN:  rd = main_mem[idx];
                  TGT_CART:  rd = cart_mem[idx];
                  default: ;
               endcase
            end
            CMD_WRITE: begin
               resolve_target(it.address, 1'b1, it.rom_write, tk, idx);
               if (tk == TGT_MAIN) begin
                  main_mem[idx]   = it.wdata;
                  main_valid[idx] = 1'b1;
               end else if (tk == TGT_CART) begin
                  cart_mem[idx] = it.wdata;
               end
            end
            CMD_SET_PAGE: page_kind[it.address[15:8]] = it.ptype;
            default: ;
         endcase
         read_data_due.push_back(rd);
      endfunction

      function void check_response(logic [DATA_W-1:0] actual);
         logic [DATA_W-1:0] want;
         if (read_data_due.size() == 0) begin
            $display("%0t unexpected transfer: expected none, actual %02h", $time, actual);
            errors++;
         end else begin
            want = read_data_due.pop_front();
            if (actual !== want) begin
               $display("%0t read_data mismatch: expected %02h, actual %02h",
                        $time, want, actual);
               errors++;
            end
         end
      endfunction

      function int pending();
         return read_data_due.size();
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  push = 1'b0;
   logic                  full;
   logic [CMD_W-1:0]      req_cmd = '0;
   logic [ADDR_W-1:0]     req_address = '0;
   logic [DATA_W-1:0]     req_write_data = '0;
   logic                  req_rom_write = 1'b0;
   logic [PTYPE_W-1:0]    req_page_type = '0;
   logic                  empty;
   logic                  pop = 1'b0;
   logic [DATA_W-1:0]     rsp_read_data;
   logic                  csr_write_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   memmap_scoreboard  sb;
   logic [ADDR_W-1:0] addr_pool [$];
   int                push_idle_pct = 0;
   int                pop_stall_pct = 0;

   banked_memory_map_decoder_top dut (
      .clock          (clock),
      .reset          (reset),
      .push           (push),
      .full           (full),
      .req_cmd        (req_cmd),
      .req_address    (req_address),
      .req_write_data (req_write_data),
      .req_rom_write  (req_rom_write),
      .req_page_type  (req_page_type),
      .empty          (empty),
      .pop            (pop),
      .rsp_read_data  (rsp_read_data),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && pop && !empty) sb.check_response(rsp_read_data);
      pop <= ($urandom_range(99) >= pop_stall_pct);
   end

   task automatic send_req(input mem_req_type raw);
      mem_req_type it;
      it = sb.legalize(raw);
      while ($urandom_range(99) < push_idle_pct) begin
         push <= 1'b0;
         @(posedge clock);
      end
      push           <= 1'b1;
      req_cmd        <= it.cmd;
      req_address    <= it.address;
      req_write_data <= it.wdata;
      req_rom_write  <= it.rom_write;
      req_page_type  <= it.ptype;
      @(posedge clock);
      while (full) @(posedge clock);
      sb.note_request(it);
      addr_pool.push_back(it.address);
      if (addr_pool.size() > POOL_DEPTH) void'(addr_pool.pop_front());
   endtask

   task automatic issue(input cmd_type cmd, input logic [ADDR_W-1:0] a,
                        input logic [DATA_W-1:0] wd, input logic romw,
                        input page_kind_type pt);
      mem_req_type it;
      it.cmd       = cmd;
      it.address   = a;
      it.wdata     = wd;
      it.rom_write = romw;
      it.ptype     = pt;
      send_req(it);
   endtask

   function automatic mem_req_type random_req();
      mem_req_type it;
      int          r;
      r = $urandom_range(99);
      if (r < 44) it.cmd = CMD_READ;
      else if (r < 89) it.cmd = CMD_WRITE;
      else if (r < 97) it.cmd = CMD_SET_PAGE;
      else it.cmd = CMD_NONE;
      r = $urandom_range(99);
      if (addr_pool.size() > 0 && r < 60)
         it.address = addr_pool[$urandom_range(addr_pool.size() - 1)];
      else if (addr_pool.size() > 0 && r < 85)
         it.address = {addr_pool[$urandom_range(addr_pool.size() - 1)][15:8],
                       8'($urandom_range(255))};
      else
         it.address = 16'($urandom_range(16'hFFFF));
      it.wdata     = 8'($urandom_range(255));
      it.rom_write = ($urandom_range(99) < 70);
      it.ptype     = page_kind_type'($urandom_range(7));
      return it;
   endfunction

   task automatic wait_drained();
      push <= 1'b0;
      while (sb.pending() > 0) @(posedge clock);
   endtask

   task automatic program_regs(input logic [BANK_W-1:0] bl, input logic [BANK_W-1:0] bh,
                               input logic [MASK_W-1:0] mask, input logic sro);
      logic [CSR_DATA_W-1:0] vals [4];
      vals[CSR_BANK_LOW]   = CSR_DATA_W'(bl);
      vals[CSR_BANK_HIGH]  = CSR_DATA_W'(bh);
      vals[CSR_CART_MASK]  = CSR_DATA_W'(mask);
      vals[CSR_SYSROM_OFF] = CSR_DATA_W'(sro);
      csr_write_en <= 1'b1;
      for (int i = 0; i < 4; i++) begin
         csr_index <= csr_index_type'(i);
         csr_wdata <= vals[i];
         @(posedge clock);
         sb.set_csr(csr_index_type'(i), vals[i]);
      end
      csr_write_en <= 1'b0;
   endtask

   initial begin
      #2000000;
      $display("TB_ERROR");
      $finish;
   end

   initial begin
      logic [BANK_W-1:0] bl;
      logic [BANK_W-1:0] bh;
      logic [MASK_W-1:0] mask;
      logic              sro;
      sb = new();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      program_regs('0, '0, MASK_RESET, 1'b0);

      issue(CMD_READ,     16'hFFFF, 8'h00, 1'b0, PT_UNDEF);
      issue(CMD_SET_PAGE, 16'h0000, 8'h00, 1'b0, PT_RAM);
      issue(CMD_WRITE,    16'h0000, 8'h00, 1'b0, PT_UNDEF);
      issue(CMD_WRITE,    16'h00FF, 8'hFF, 1'b0, PT_UNDEF);
      issue(CMD_SET_PAGE, 16'h4100, 8'h00, 1'b0, PT_MRAM);
      issue(CMD_WRITE,    16'h41AB, 8'hA5, 1'b0, PT_UNDEF);
      issue(CMD_READ,     16'h41AB, 8'h00, 1'b0, PT_UNDEF);
      issue(CMD_SET_PAGE, 16'h1000, 8'h00, 1'b0, PT_ROM);
      issue(CMD_WRITE,    16'h1000, 8'h3C, 1'b0, PT_UNDEF);
      issue(CMD_WRITE,    16'h1000, 8'h5A, 1'b1, PT_UNDEF);
      issue(CMD_READ,     16'h1000, 8'h00, 1'b0, PT_UNDEF);
      issue(CMD_SET_PAGE, 16'h2000, 8'h00, 1'b0, PT_MROM);
      issue(CMD_READ,     16'h20FF, 8'h00, 1'b0, PT_UNDEF);
      issue(CMD_SET_PAGE, 16'h3000, 8'h00, 1'b0, PT_CART);
      issue(CMD_WRITE,    16'h3077, 8'h77, 1'b1, PT_UNDEF);
      issue(CMD_READ,     16'h3077, 8'h00, 1'b0, PT_UNDEF);
      issue(CMD_SET_PAGE, 16'hF100, 8'h00, 1'b0, PT_MULTI);
      issue(CMD_WRITE,    16'hF123, 8'hC3, 1'b1, PT_UNDEF);
      issue(CMD_WRITE,    16'hF123, 8'h00, 1'b0, PT_UNDEF);
      issue(CMD_READ,     16'hF123, 8'h00, 1'b0, PT_UNDEF);
      issue(CMD_SET_PAGE, 16'h0100, 8'h00, 1'b0, PT_MULTI);
      issue(CMD_WRITE,    16'h0150, 8'h96, 1'b1, PT_UNDEF);
      issue(CMD_READ,     16'h0150, 8'h00, 1'b0, PT_UNDEF);
      issue(CMD_SET_PAGE, 16'hFF00, 8'h00, 1'b0, PT_MMULTI);
      issue(CMD_WRITE,    16'hFFFF, 8'h81, 1'b1, PT_UNDEF);
      issue(CMD_READ,     16'hFFFF, 8'h00, 1'b0, PT_UNDEF);
      issue(CMD_NONE,     16'hFFFF, 8'hFF, 1'b1, PT_MMULTI);

      for (int ph = 0; ph < PHASES; ph++) begin
         wait_drained();
         bl   = 8'($urandom_range(255));
         bh   = 8'($urandom_range(255));
         mask = 20'($urandom_range(20'hFFFFF));
         sro  = 1'($urandom_range(1));
         case (ph)
            0: begin
               bl = '0; bh = '0; mask = MASK_RESET; sro = 1'b0;
            end
            1: begin
               bl = '1; bh = '1; mask = MASK_RESET; sro = 1'b1;
            end
            2: begin
               mask = '0; sro = 1'b1;
            end
            3: begin
               bl = '0; bh = '1; mask = MASK_RESET;
            end
            default: ;
         endcase
         program_regs(bl, bh, mask, sro);
         case (ph % 4)
            0: begin push_idle_pct = 0;  pop_stall_pct = 0;  end
            1: begin push_idle_pct = 52; pop_stall_pct = 0;  end
            2: begin push_idle_pct = 0;  pop_stall_pct = 52; end
            default: begin push_idle_pct = 14; pop_stall_pct = 14; end
         endcase
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (ph == 3 && n == PHASE_ITEMS / 2) wait_drained();
            send_req(random_req());
         end
      end

      wait_drained();
      repeat (10) @(posedge clock);
      if (sb.errors == 0) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
   end

endmodule
